### rtl/core/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg
// shared constants and operation codes of the vector alu
// ----------------------------------------------------------------------------
`default_nettype none

package v3alu_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int OP_BITS       = 3;
	localparam int IN_USER_BITS  = OP_BITS + 1;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_SCALE = 3'd2,
		OP_DOT   = 3'd3,
		OP_CROSS = 3'd4
	} op_t;

endpackage

`default_nettype wire

### rtl/core/v3alu_lane.sv
// ----------------------------------------------------------------------------
// v3alu_lane
// one component lane: add, subtract, products, saturation and square
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_lane #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                    clk,
	input  logic                    adv,
	input  v3alu_pkg::op_t          op,
	input  logic signed [W-1:0]     a_i,
	input  logic signed [W-1:0]     b_i,
	input  logic signed [W-1:0]     scl,
	input  logic signed [W-1:0]     a_n1,
	input  logic signed [W-1:0]     b_n2,
	input  logic signed [W-1:0]     a_n2,
	input  logic signed [W-1:0]     b_n1,
	output logic signed [W-1:0]     r_s2,
	output logic signed [2*W-1:0]   fp_s2,
	output logic                    sat_s2,
	output logic [2*W-1:0]          sq_s3
);
	import v3alu_pkg::*;

	localparam int PW = 2 * W;
	localparam int VW = 2 * W + 1;

	logic signed [W-1:0]  mul_a;
	logic signed [W-1:0]  mul_b;
	logic signed [PW-1:0] p_s1;
	logic signed [PW-1:0] q_s1;
	logic signed [W:0]    sum_s1;
	op_t                  op_s1;
	logic signed [PW-1:0] fp;
	logic signed [PW-1:0] fq;
	logic signed [VW-1:0] v;
	logic                 chk;
	logic                 ovf;
	logic signed [W-1:0]  rc;
	logic signed [PW-1:0] sq;

	always_comb begin
		mul_a = (op == OP_CROSS) ? a_n1 : a_i;
		if (op == OP_CROSS) begin
			mul_b = b_n2;
		end else if (op == OP_SCALE) begin
			mul_b = scl;
		end else begin
			mul_b = b_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1   <= mul_a * mul_b;
			q_s1   <= a_n2 * b_n1;
			sum_s1 <= (op == OP_ADD) ? ({a_i[W-1], a_i} + {b_i[W-1], b_i})
			                         : ({a_i[W-1], a_i} - {b_i[W-1], b_i});
			op_s1  <= op;
		end
	end

	always_comb begin
		fp = p_s1 >>> F;
		fq = q_s1 >>> F;
		unique case (op_s1)
			OP_ADD, OP_SUB: begin
				v   = {{(VW-W-1){sum_s1[W]}}, sum_s1};
				chk = 1'b1;
			end
			OP_SCALE: begin
				v   = {fp[PW-1], fp};
				chk = 1'b1;
			end
			OP_CROSS: begin
				v   = {fp[PW-1], fp} - {fq[PW-1], fq};
				chk = 1'b1;
			end
			default: begin
				v   = '0;
				chk = 1'b0;
			end
		endcase
		ovf = chk && !((&v[VW-1:W-1]) || !(|v[VW-1:W-1]));
		if (ovf) begin
			rc = v[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			rc = v[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2   <= rc;
			fp_s2  <= fp;
			sat_s2 <= ovf;
		end
	end

	assign sq = r_s2 * r_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3 <= sq;
		end
	end

endmodule

`default_nettype wire

### rtl/core/v3alu_isqrt.sv
// ----------------------------------------------------------------------------
// v3alu_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_isqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           adv,
	input  logic [2*W-1:0] sum_sq,
	output logic [W-1:0]   root
);
	localparam int SW = 2 * W;

	logic [SW-1:0] rem_s [W];
	logic [SW-1:0] res_s [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		localparam logic [SW-1:0] BIT = SW'(1) << (2 * (W - 1 - k));
		logic [SW-1:0] rem_in;
		logic [SW-1:0] res_in;
		logic [SW-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = sum_sq;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_s[W-1][W-1:0];

endmodule

`default_nettype wire

### rtl/core/v3alu_div.sv
// ----------------------------------------------------------------------------
// v3alu_div
// pipelined restoring divider for the unit vector, rounded quotient
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-1:0] mag,
	input  logic [W-1:0] len,
	output logic [F:0]   quo
);
	localparam int NW = W + F;
	localparam int RW = W + 1;

	logic [NW-1:0] num;
	logic [NW-1:0] n_s   [F+2];
	logic [W-1:0]  m_s   [F+2];
	logic [W-1:0]  rem_s [F+2];
	logic [F:0]    q_s   [F+2];

	assign num = {mag, {F{1'b0}}} + NW'(len >> 1);

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s[0]   <= num;
			m_s[0]   <= len;
			rem_s[0] <= W'(num >> (F + 1));
			q_s[0]   <= '0;
		end
	end

	for (genvar j = 1; j <= F + 1; j++) begin : g_stage
		logic [RW-1:0] trial;
		logic          take;

		assign trial = {rem_s[j-1], n_s[j-1][F+1-j]};
		assign take  = trial >= {1'b0, m_s[j-1]};

		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[j]   <= n_s[j-1];
				m_s[j]   <= m_s[j-1];
				rem_s[j] <= take ? W'(trial - {1'b0, m_s[j-1]}) : W'(trial);
				q_s[j]   <= {q_s[j-1][F-1:0], take};
			end
		end
	end

	assign quo = q_s[F+1];

endmodule

`default_nettype wire

### rtl/core/vec3_alu_with_normalize.sv
// ----------------------------------------------------------------------------
// vec3_alu_with_normalize
// three-component fixed point vector alu with optional normalization
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one result per item, in order. The stages
// are two product stages, one merge stage for the dot sum, one sum-of-squares
// stage, WORD_BITS square root stages, FRAC_BITS + 2 divider stages and the
// output register. Three lanes, one per component, hold the multipliers; a
// result not taken holds the whole pipeline and s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module vec3_alu_with_normalize #(
	parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF,
	localparam int IN_DW  = ((7 * WORD_BITS + 7) / 8) * 8,
	localparam int OUT_DW = ((4 * WORD_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
	input  logic [IN_DW-1:0]                    s_tdata,
	// op, make_unit
	input  logic [v3alu_pkg::IN_USER_BITS-1:0]  s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// r_x, r_y, r_z, dot_value
	output logic [OUT_DW-1:0]                   m_tdata,
	// saturated
	output logic                                m_tuser
);
	import v3alu_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int DW = 2 * W + 2;
	localparam int L  = W + F + 2;

	typedef struct packed {
		logic [2:0][W-1:0] r;
		logic [W-1:0]      dot;
		logic              sat;
		logic              norm;
	} side_t;

	logic                     adv;
	logic signed [W-1:0]      a [3];
	logic signed [W-1:0]      b [3];
	logic signed [W-1:0]      scl;
	op_t                      op_in;
	logic signed [W-1:0]      r_s2  [3];
	logic signed [PW-1:0]     fp_s2 [3];
	logic                     lsat_s2 [3];
	logic [PW-1:0]            sq_s3 [3];
	logic                     v_s1, v_s2, v_s3;
	op_t                      op_s1, op_s2;
	logic                     mu_s1, mu_s2;
	logic signed [DW-1:0]     dsum;
	logic                     dovf;
	logic [W-1:0]             dclamp;
	side_t                    side_s3;
	logic [PW-1:0]            ssum_s4;
	logic [PW-1:0]            ssum;
	side_t                    side_q [L+1];
	logic                     vld_q  [L+1];
	logic [W-1:0]             root;
	logic [F:0]               quo [3];
	logic [2:0][W-1:0]        res_r;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign a[i] = s_tdata[i*W +: W];
		assign b[i] = s_tdata[(i+3)*W +: W];
	end
	assign scl   = s_tdata[6*W +: W];
	assign op_in = op_t'(s_tuser[OP_BITS-1:0]);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		v3alu_lane #(.W(W), .F(F)) u_lane (
			.clk    (clk),
			.adv    (adv),
			.op     (op_in),
			.a_i    (a[i]),
			.b_i    (b[i]),
			.scl    (scl),
			.a_n1   (a[(i+1)%3]),
			.b_n2   (b[(i+2)%3]),
			.a_n2   (a[(i+2)%3]),
			.b_n1   (b[(i+1)%3]),
			.r_s2   (r_s2[i]),
			.fp_s2  (fp_s2[i]),
			.sat_s2 (lsat_s2[i]),
			.sq_s3  (sq_s3[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op_in;
			op_s2 <= op_s1;
			mu_s1 <= s_tuser[OP_BITS];
			mu_s2 <= mu_s1;
		end
	end

	// dot sum merge
	always_comb begin
		dsum = {{2{fp_s2[0][PW-1]}}, fp_s2[0]} + {{2{fp_s2[1][PW-1]}}, fp_s2[1]}
		     + {{2{fp_s2[2][PW-1]}}, fp_s2[2]};
		dovf = (op_s2 == OP_DOT) && !((&dsum[DW-1:W-1]) || !(|dsum[DW-1:W-1]));
		if (op_s2 != OP_DOT) begin
			dclamp = '0;
		end else if (dovf) begin
			dclamp = dsum[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			dclamp = dsum[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				side_s3.r[i] <= r_s2[i];
			end
			side_s3.dot  <= dclamp;
			side_s3.sat  <= dovf || lsat_s2[0] || lsat_s2[1] || lsat_s2[2];
			side_s3.norm <= mu_s2 && (op_s2 == OP_ADD || op_s2 == OP_SUB ||
			                op_s2 == OP_SCALE || op_s2 == OP_CROSS);
		end
	end

	assign ssum = sq_s3[0] + sq_s3[1] + sq_s3[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			ssum_s4 <= ssum;
			side_q[0].r    <= side_s3.r;
			side_q[0].dot  <= side_s3.dot;
			side_q[0].sat  <= side_s3.sat;
			side_q[0].norm <= side_s3.norm && (ssum != '0);
			for (int k = 1; k <= L; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= L; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= v_s3;
			for (int k = 1; k <= L; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	v3alu_isqrt #(.W(W)) u_isqrt (
		.clk    (clk),
		.adv    (adv),
		.sum_sq (ssum_s4),
		.root   (root)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		logic [W-1:0] mag;
		assign mag = side_q[W].r[i][W-1] ? W'(-side_q[W].r[i]) : side_q[W].r[i];

		v3alu_div #(.W(W), .F(F)) u_div (
			.clk (clk),
			.adv (adv),
			.mag (mag),
			.len (root),
			.quo (quo[i])
		);

		assign res_r[i] = !side_q[L].norm ? side_q[L].r[i] :
		                  side_q[L].r[i][W-1] ? W'(-W'(quo[i])) : W'(quo[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= vld_q[L];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= OUT_DW'({side_q[L].dot, res_r[2], res_r[1], res_r[0]});
			m_tuser <= side_q[L].sat;
		end
	end

endmodule

`default_nettype wire

### test/vec3_alu_with_normalize_tb.sv
// ----------------------------------------------------------------------------
// vec3_alu_with_normalize_tb
// drives directed and random vector operations through the stream ports and
// checks every result item in order against a fixed point predictor or a known table row
// ----------------------------------------------------------------------------
`default_nettype none

module vec3_alu_with_normalize_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import v3alu_pkg::*;

	localparam int WB = 32;
	localparam int FB = 16;
	localparam int LATENCY = WB + FB + 7;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 2000;

	typedef struct packed {
		logic [2:0]         op;
		logic               make_unit;
		logic signed [31:0] ax, ay, az, bx, by, bz, sf;
	} vec_item_t;

	typedef struct packed {
		logic signed [31:0] rx, ry, rz, dot;
		logic               sat;
	} vec_res_t;

	typedef struct {
		vec_item_t item;
		logic      known;
		vec_res_t  res;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7*WB-1:0] s_tdata = '0;
	logic [IN_USER_BITS-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [4*WB-1:0] m_tdata;
	logic m_tuser;

	vec_res_t pending_results[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit sending_done = 1'b0;
	bit hold_done = 1'b0;

	vec3_alu_with_normalize u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint sat_word(longint v, ref bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// product floored to the fraction point
	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b;
		return p >>> FB;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] s);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= root + bitv) begin
				s = s - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic vec_res_t vec_alu_result(vec_item_t it);
		longint a[3], b[3], r[3], d, s;
		logic [63:0] mg, sq, len, q;
		bit sat, is_vec;
		vec_res_t res;
		a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
		b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
		s = it.sf;
		r[0] = 0; r[1] = 0; r[2] = 0; d = 0;
		sat = 1'b0;
		is_vec = 1'b1;
		case (it.op)
			OP_ADD: for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] + b[i], sat);
			OP_SUB: for (int i = 0; i < 3; i++) r[i] = sat_word(a[i] - b[i], sat);
			OP_SCALE: for (int i = 0; i < 3; i++) r[i] = sat_word(qmul(a[i], s), sat);
			OP_DOT: begin
				d = sat_word(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]), sat);
				is_vec = 1'b0;
			end
			OP_CROSS: begin
				r[0] = sat_word(qmul(a[1], b[2]) - qmul(a[2], b[1]), sat);
				r[1] = sat_word(qmul(a[2], b[0]) - qmul(a[0], b[2]), sat);
				r[2] = sat_word(qmul(a[0], b[1]) - qmul(a[1], b[0]), sat);
			end
			default: is_vec = 1'b0;
		endcase
		if (is_vec && it.make_unit) begin
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				mg = r[i] < 0 ? -r[i] : r[i];
				sq = sq + mg * mg;
			end
			if (sq != 0) begin
				len = int_sqrt(sq);
				for (int i = 0; i < 3; i++) begin
					mg = r[i] < 0 ? -r[i] : r[i];
					q = ((mg << FB) + (len >> 1)) / len;
					r[i] = r[i] < 0 ? -longint'(q) : longint'(q);
				end
			end
		end
		res.rx = r[0][31:0];
		res.ry = r[1][31:0];
		res.rz = r[2][31:0];
		res.dot = d[31:0];
		res.sat = sat;
		return res;
	endfunction

	function automatic vec_item_t random_item();
		vec_item_t it;
		logic signed [31:0] w[7];
		for (int i = 0; i < 7; i++) begin
			case ($urandom_range(0, 5))
				0: w[i] = $urandom;
				1: w[i] = $signed($urandom_range(0, 65536 * 4)) - 32'sd131072;
				2: w[i] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
				3: w[i] = $signed($urandom_range(0, 40)) - 32'sd20;
				default: w[i] = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
			endcase
		end
		it.op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		it.make_unit = 1'($urandom_range(0, 1));
		{it.ax, it.ay, it.az, it.bx, it.by, it.bz, it.sf} = {w[0], w[1], w[2], w[3], w[4],
			w[5], w[6]};
		return it;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) != 0)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	// offer one item and wait for its handshake
	task automatic push_item(vec_item_t it);
		s_tdata <= {it.sf, it.bz, it.by, it.bx, it.az, it.ay, it.ax};
		s_tuser <= {it.make_unit, it.op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(vec_alu_result(it));
	endtask

	task automatic send_with_gap(vec_item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push_item(it);
	endtask

	function automatic vec_item_t mk(logic [2:0] op, logic mu, logic signed [31:0] ax,
		logic signed [31:0] ay, logic signed [31:0] az, logic signed [31:0] bx,
		logic signed [31:0] by, logic signed [31:0] bz, logic signed [31:0] sf);
		vec_item_t it;
		it.op = op; it.make_unit = mu;
		it.ax = ax; it.ay = ay; it.az = az; it.bx = bx; it.by = by; it.bz = bz; it.sf = sf;
		return it;
	endfunction

	localparam logic signed [31:0] MAXW = 32'sh7fffffff;
	localparam logic signed [31:0] MINW = 32'sh80000000;
	localparam logic signed [31:0] ONE = 32'sh00010000;

	table_row_t directed[$];

	task automatic add_row(vec_item_t it, logic known, vec_res_t r);
		table_row_t row;
		row.item = it;
		row.known = known;
		row.res = r;
		directed.push_back(row);
	endtask

	initial begin
		vec_res_t z;
		vec_item_t it;
		z = '0;
		add_row(mk(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
		add_row(mk(OP_ADD, 0, MAXW, MINW, 1, 1, -1, 2, 0), 1, '{MAXW, MINW, 3, 0, 1});
		add_row(mk(OP_SUB, 0, MINW, MAXW, 5, 1, -1, 2, 0), 1, '{MINW, MAXW, 3, 0, 1});
		add_row(mk(OP_SUB, 1, ONE, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(OP_SCALE, 0, MAXW, MINW, ONE, 0, 0, 0, MAXW), 0, z);
		add_row(mk(OP_SCALE, 1, 3 * ONE, 4 * ONE, 0, 0, 0, 0, ONE), 1,
			'{32'sd39322, 32'sd52429, 0, 0, 0});
		add_row(mk(OP_SCALE, 0, -1, 1, -1, 0, 0, 0, 1), 0, z);
		add_row(mk(OP_DOT, 1, ONE, ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 0), 1,
			'{0, 0, 0, 9 * ONE, 0});
		add_row(mk(OP_DOT, 0, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, 0), 1, '{0, 0, 0, MAXW, 1});
		add_row(mk(OP_DOT, 0, MINW, MINW, MINW, MAXW, MAXW, MAXW, 0), 1, '{0, 0, 0, MINW, 1});
		add_row(mk(OP_CROSS, 0, ONE, 0, 0, 0, ONE, 0, 0), 1, '{0, 0, ONE, 0, 0});
		add_row(mk(OP_CROSS, 1, 2 * ONE, 0, 0, 0, 3 * ONE, 0, 0), 1, '{0, 0, ONE, 0, 0});
		add_row(mk(OP_CROSS, 1, ONE, ONE, 0, ONE, ONE, 0, 0), 1, z);
		add_row(mk(OP_CROSS, 0, MAXW, MINW, MAXW, MINW, MAXW, MINW, 0), 0, z);
		add_row(mk(3'd5, 1, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW), 1, z);
		add_row(mk(3'd6, 0, -1, -1, -1, -1, -1, -1, -1), 1, z);
		add_row(mk(3'd7, 1, MINW, MINW, MINW, MINW, MINW, MINW, MINW), 1, z);
		add_row(mk(OP_ADD, 1, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, 0), 0, z);
		add_row(mk(OP_SUB, 1, 1, -1, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(OP_SCALE, 1, MINW, MINW, MINW, 0, 0, 0, MINW), 0, z);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			push_item(directed[i].item);
			if (directed[i].known)
				pending_results[$] = directed[i].res;
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			it = random_item();
			if (n == 600) begin
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			if (n >= 300 && n < 400)
				push_item(it);
			else
				send_with_gap(it);
		end
		s_tvalid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver: random stalls plus one long hold-off while items keep coming
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && pending_results.size() > 40) begin
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_done = 1'b1;
			end
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		vec_res_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tuser};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
					got.dot !== want.dot || got.sat !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp r=%h %h %h dot=%h sat=%b got r=%h %h %h dot=%h sat=%b",
							want.rx, want.ry, want.rz, want.dot, want.sat,
							got.rx, got.ry, got.rz, got.dot, got.sat);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("vec3_alu_with_normalize_tb NOT OK");
			$finish;
		end
	end

	initial begin
		while (!(sending_done && pending_results.size() == 0))
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("vec3_alu_with_normalize_tb OK");
		else
			$display("vec3_alu_with_normalize_tb NOT OK");
		$finish;
	end
endmodule

`default_nettype wire
